FILE: rtl/dcp_pkg.sv
`timescale 1ns / 1ps
package dcp_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned LimW     = 31;
  localparam int unsigned MassW    = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned MagW  = PosW;
  localparam int unsigned RootW = PosW + 1;
  localparam int unsigned ErrW  = ((RootW > LimW) ? RootW : LimW) + 1;
  localparam int unsigned MerrW = ErrW - 1;
  localparam int unsigned DivW  = MassW + 1;
  localparam int unsigned ProdW = MagW + MerrW;
  localparam int unsigned NumW  = ProdW + MassW;
  localparam int unsigned DenW  = RootW + DivW;
  localparam int unsigned QuoW  = MerrW;
  localparam int unsigned SumW  = ((PosW > QuoW + 2) ? PosW : QuoW + 2) + 1;
  localparam int unsigned Lanes = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLimit      = 8'd0,
    CfgMode       = 8'd1,
    CfgMassFirst  = 8'd2,
    CfgMassSecond = 8'd3
  } dcp_cfg_e;

  typedef struct packed {
    logic signed [PosW-1:0] first_x;
    logic signed [PosW-1:0] first_y;
    logic signed [PosW-1:0] second_x;
    logic signed [PosW-1:0] second_y;
    logic                   first_fixed;
    logic                   second_fixed;
  } dcp_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] new_first_x;
    logic signed [PosW-1:0] new_first_y;
    logic signed [PosW-1:0] new_second_x;
    logic signed [PosW-1:0] new_second_y;
    logic                   corrected;
  } dcp_out_t;

  typedef struct packed {
    logic [Lanes-1:0][PosW-1:0] pos;
    logic [MagW-1:0]            mdx;
    logic [MagW-1:0]            mdy;
    logic                       ndx;
    logic                       ndy;
    logic                       f1;
    logic                       f2;
  } dcp_geo_t;

  typedef struct packed {
    logic [Lanes-1:0][PosW-1:0] pos;
    logic [Lanes-1:0]           neg;
    logic                       move;
  } dcp_mov_t;

endpackage

FILE: rtl/dcp_sqrt.sv
`timescale 1ns / 1ps
module dcp_sqrt
  import dcp_pkg::*;
#(
  parameter int unsigned RtW = RootW,
  parameter int unsigned SbW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [2*RtW-1:0]     rad_i,
  input  logic [SbW-1:0]       sb_i,
  output logic                 valid_o,
  output logic [RtW-1:0]       root_o,
  output logic [SbW-1:0]       sb_o
);

  localparam int unsigned RemW = RtW + 2;
  localparam int unsigned RadW = 2 * RtW;

  logic [RtW:0]      v_q;
  logic [RemW-1:0]   rem_q  [RtW+1];
  logic [RtW-1:0]    root_q [RtW+1];
  logic [RadW-1:0]   rad_q  [RtW+1];
  logic [SbW-1:0]    sb_q   [RtW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[RtW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    rad_q[0]  <= rad_i;
    sb_q[0]   <= sb_i;
  end

  for (genvar i = 1; i <= RtW; i++) begin : g_step
    logic [RemW+1:0] t;
    logic [RemW+1:0] trial;
    logic            ge;
    assign t     = {rem_q[i-1], rad_q[i-1][RadW-1 -: 2]};
    assign trial = (RemW+2)'({root_q[i-1], 2'b01});
    assign ge    = t >= trial;
    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? RemW'(t - trial) : RemW'(t);
      root_q[i] <= {root_q[i-1][RtW-2:0], ge};
      rad_q[i]  <= rad_q[i-1] << 2;
      sb_q[i]   <= sb_q[i-1];
    end
  end

  assign valid_o = v_q[RtW];
  assign root_o  = root_q[RtW];
  assign sb_o    = sb_q[RtW];

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[RtW] |-> rem_q[RtW] <= RemW'({root_q[RtW], 1'b0}))
    else $error("Square root remainder exceeds twice the root.");

endmodule

FILE: rtl/dcp_div.sv
`timescale 1ns / 1ps
module dcp_div
  import dcp_pkg::*;
#(
  parameter int unsigned NW  = NumW,
  parameter int unsigned DW  = DenW,
  parameter int unsigned QW  = QuoW,
  parameter int unsigned LN  = Lanes,
  parameter int unsigned SbW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [LN-1:0][NW-1:0]    num_i,
  input  logic [LN-1:0][DW-1:0]    den_i,
  input  logic [SbW-1:0]           sb_i,
  output logic                     valid_o,
  output logic [LN-1:0][QW:0]      quo_o,
  output logic [SbW-1:0]           sb_o
);

  logic [QW:0]        v_q;
  logic               vo_q;
  logic [SbW-1:0]     sb_q  [QW+1];
  logic [SbW-1:0]     sbo_q;
  logic [DW-1:0]      rem_q [LN][QW+1];
  logic [DW-1:0]      den_q [LN][QW+1];
  logic [QW-1:0]      low_q [LN][QW+1];
  logic [QW-1:0]      q_q   [LN][QW+1];
  logic [LN-1:0][QW:0] quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      v_q  <= {v_q[QW-1:0], valid_i};
      vo_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb_i;
    sbo_q   <= sb_q[QW];
  end

  for (genvar i = 1; i <= QW; i++) begin : g_sb
    always_ff @(posedge clk_i) begin
      sb_q[i] <= sb_q[i-1];
    end
  end

  for (genvar l = 0; l < LN; l++) begin : g_lane
    logic round_up;

    always_ff @(posedge clk_i) begin
      rem_q[l][0] <= DW'(num_i[l][NW-1:QW]);
      low_q[l][0] <= num_i[l][QW-1:0];
      den_q[l][0] <= den_i[l];
      q_q[l][0]   <= '0;
    end

    for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [DW:0] t;
      logic        ge;
      assign t  = {rem_q[l][i-1], low_q[l][i-1][QW-1]};
      assign ge = t >= {1'b0, den_q[l][i-1]};
      always_ff @(posedge clk_i) begin
        rem_q[l][i] <= ge ? DW'(t - {1'b0, den_q[l][i-1]}) : DW'(t);
        low_q[l][i] <= low_q[l][i-1] << 1;
        den_q[l][i] <= den_q[l][i-1];
        q_q[l][i]   <= QW'({q_q[l][i-1], ge});
      end
    end

    assign round_up = {rem_q[l][QW], 1'b0} >= {1'b0, den_q[l][QW]};

    always_ff @(posedge clk_i) begin
      quo_q[l] <= {1'b0, q_q[l][QW]} + (QW+1)'(round_up);
    end

    a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[0] && den_q[l][0] != '0 |-> rem_q[l][0] < den_q[l][0])
      else $error("Quotient does not fit the divider width.");
  end

  assign valid_o = vo_q;
  assign quo_o   = quo_q;
  assign sb_o    = sbo_q;

endmodule

FILE: rtl/distance_constraint_projection_top.sv
`timescale 1ns / 1ps
// Projects a pair of 2D Q16.16 points onto a distance constraint. An item is taken
// whenever start is high (busy stays low), one per clock, and its word appears on
// result_o with result_valid_o high for one cycle; the receiver cannot stall the
// block, so results must be taken as they come. The square root resolves one root
// bit per stage, and the divider resolves one quotient bit per stage. Configuration
// writes are always ready and should be made only while no word is in flight.
module distance_constraint_projection_top
  import dcp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dcp_in_t             item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                result_valid_o,
  output dcp_out_t            result_o
);

  localparam int unsigned GeoW   = $bits(dcp_geo_t);
  localparam int unsigned MovW   = $bits(dcp_mov_t);
  localparam int unsigned DivLat = QuoW + 2;

  logic [LimW-1:0]  limit_q;
  logic             mode_q;
  logic [MassW-1:0] m1_q;
  logic [MassW-1:0] m2_q;

  logic v0_q, v1_q, v2_q, v3_q, v5_q, v6_q, v7_q, vo_q;

  dcp_in_t  in0_q;
  dcp_geo_t geo1_q, geo2_q, geo3_q, geo4;
  logic [2*PosW-1:0]  sqx2_q, sqy2_q;
  logic [2*RootW-1:0] rad3_q;

  logic               v4;
  logic [RootW-1:0]   root4;
  logic [GeoW-1:0]    geo4_sb;

  logic signed [PosW:0] dx_s, dy_s;
  logic [ErrW-1:0]      err;
  logic                 err_neg, err_pos, viol;
  logic [MassW:0]       msum;
  logic [MassW-1:0]     n1_d, n2_d;
  logic [DivW-1:0]      d1_d, d2_d;

  dcp_mov_t          mov5_q, mov6_q, mov7_q, mov8;
  logic [MovW-1:0]   mov8_sb;
  logic [MerrW-1:0]  merr5_q;
  logic [RootW-1:0]  root5_q;
  logic [MagW-1:0]   mdx5_q, mdy5_q;
  logic [MassW-1:0]  n1_5_q, n2_5_q, n1_6_q, n2_6_q;
  logic [DivW-1:0]   d1_5_q, d2_5_q;
  logic [ProdW-1:0]  pcx6_q, pcy6_q;
  logic [DenW-1:0]   den1_6_q, den2_6_q;

  logic [Lanes-1:0][NumW-1:0] num7_q;
  logic [Lanes-1:0][DenW-1:0] den7_q;

  logic                      v8;
  logic [Lanes-1:0][QuoW:0]  quo8;
  dcp_out_t                  out_d, out_q;

  function automatic logic [PosW-1:0] apply_move(logic [PosW-1:0] pos,
                                                 logic [QuoW:0] q, logic neg);
    logic signed [SumW-1:0] p_ext;
    logic signed [SumW-1:0] m_ext;
    logic signed [SumW-1:0] s;
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    p_ext = SumW'($signed(pos));
    m_ext = SumW'(q);
    if (neg) begin
      m_ext = -m_ext;
    end
    s  = p_ext + m_ext;
    hi = SumW'({1'b0, {(PosW-1){1'b1}}});
    lo = ~hi;
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return PosW'(s);
  endfunction

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      mode_q  <= 1'b0;
      m1_q    <= MassW'(1);
      m2_q    <= MassW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dcp_cfg_e'(cfg_index_i))
        CfgLimit:      limit_q <= cfg_data_i[LimW-1:0];
        CfgMode:       mode_q  <= cfg_data_i[0];
        CfgMassFirst:  m1_q    <= cfg_data_i[MassW-1:0];
        CfgMassSecond: m2_q    <= cfg_data_i[MassW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v5_q <= v4;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vo_q <= v8;
    end
  end

  assign dx_s = $signed({in0_q.second_x[PosW-1], in0_q.second_x})
              - $signed({in0_q.first_x[PosW-1], in0_q.first_x});
  assign dy_s = $signed({in0_q.second_y[PosW-1], in0_q.second_y})
              - $signed({in0_q.first_y[PosW-1], in0_q.first_y});

  always_ff @(posedge clk_i) begin
    in0_q <= item_i;

    geo1_q.pos <= {in0_q.first_x, in0_q.first_y, in0_q.second_x, in0_q.second_y};
    geo1_q.mdx <= dx_s[PosW] ? PosW'(-dx_s) : PosW'(dx_s);
    geo1_q.mdy <= dy_s[PosW] ? PosW'(-dy_s) : PosW'(dy_s);
    geo1_q.ndx <= dx_s[PosW];
    geo1_q.ndy <= dy_s[PosW];
    geo1_q.f1  <= in0_q.first_fixed;
    geo1_q.f2  <= in0_q.second_fixed;

    geo2_q <= geo1_q;
    sqx2_q <= geo1_q.mdx * geo1_q.mdx;
    sqy2_q <= geo1_q.mdy * geo1_q.mdy;

    geo3_q <= geo2_q;
    rad3_q <= (2*RootW)'(sqx2_q) + (2*RootW)'(sqy2_q);
  end

  dcp_sqrt #(
    .RtW (RootW),
    .SbW (GeoW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (rad3_q),
    .sb_i    (geo3_q),
    .valid_o (v4),
    .root_o  (root4),
    .sb_o    (geo4_sb)
  );

  assign geo4 = dcp_geo_t'(geo4_sb);

  assign err     = ErrW'(root4) - ErrW'(limit_q);
  assign err_neg = err[ErrW-1];
  assign err_pos = !err_neg && (err != '0);
  assign viol    = mode_q ? err_pos : err_neg;
  assign msum    = {1'b0, m1_q} + {1'b0, m2_q};

  always_comb begin
    n1_d = '0;
    n2_d = '0;
    d1_d = DivW'(1);
    d2_d = DivW'(1);
    if (geo4.f1) begin
      n2_d = MassW'(1);
    end else if (geo4.f2) begin
      n1_d = MassW'(1);
    end else if (msum == '0) begin
      n1_d = MassW'(1);
      n2_d = MassW'(1);
      d1_d = DivW'(2);
      d2_d = DivW'(2);
    end else begin
      n1_d = m2_q;
      n2_d = m1_q;
      d1_d = msum;
      d2_d = msum;
    end
  end

  always_ff @(posedge clk_i) begin
    mov5_q.pos  <= geo4.pos;
    mov5_q.neg  <= {geo4.ndx ^ err_neg, geo4.ndy ^ err_neg,
                    !geo4.ndx ^ err_neg, !geo4.ndy ^ err_neg};
    mov5_q.move <= viol && (root4 != '0) && !(geo4.f1 && geo4.f2);
    merr5_q     <= err_neg ? MerrW'(-err) : MerrW'(err);
    root5_q     <= root4;
    mdx5_q      <= geo4.mdx;
    mdy5_q      <= geo4.mdy;
    n1_5_q      <= n1_d;
    n2_5_q      <= n2_d;
    d1_5_q      <= d1_d;
    d2_5_q      <= d2_d;

    mov6_q   <= mov5_q;
    pcx6_q   <= mdx5_q * merr5_q;
    pcy6_q   <= mdy5_q * merr5_q;
    den1_6_q <= root5_q * d1_5_q;
    den2_6_q <= root5_q * d2_5_q;
    n1_6_q   <= n1_5_q;
    n2_6_q   <= n2_5_q;

    mov7_q    <= mov6_q;
    num7_q[3] <= pcx6_q * n1_6_q;
    num7_q[2] <= pcy6_q * n1_6_q;
    num7_q[1] <= pcx6_q * n2_6_q;
    num7_q[0] <= pcy6_q * n2_6_q;
    den7_q    <= {den1_6_q, den1_6_q, den2_6_q, den2_6_q};
  end

  dcp_div #(
    .NW  (NumW),
    .DW  (DenW),
    .QW  (QuoW),
    .LN  (Lanes),
    .SbW (MovW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .den_i   (den7_q),
    .sb_i    (mov7_q),
    .valid_o (v8),
    .quo_o   (quo8),
    .sb_o    (mov8_sb)
  );

  assign mov8 = dcp_mov_t'(mov8_sb);

  always_comb begin
    out_d.new_first_x  = mov8.pos[3];
    out_d.new_first_y  = mov8.pos[2];
    out_d.new_second_x = mov8.pos[1];
    out_d.new_second_y = mov8.pos[0];
    out_d.corrected    = mov8.move;
    if (mov8.move) begin
      out_d.new_first_x  = apply_move(mov8.pos[3], quo8[3], mov8.neg[3]);
      out_d.new_first_y  = apply_move(mov8.pos[2], quo8[2], mov8.neg[2]);
      out_d.new_second_x = apply_move(mov8.pos[1], quo8[1], mov8.neg[1]);
      out_d.new_second_y = apply_move(mov8.pos[0], quo8[0], mov8.neg[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = vo_q;
  assign result_o       = out_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q && mov6_q.move |-> den1_6_q != '0 && den2_6_q != '0)
    else $error("A moving pair reached the divider with a zero denominator.");

  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q |-> ##(DivLat + 1) result_valid_o)
    else $error("Result strobe is out of step with the divider input.");

endmodule
